// File: rtl/sats_pkg.sv
// Package for the summed-area table stream core.
// Field widths, configuration register codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package sats_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int SUM_W          = 28;
  localparam int CFG_W          = 7;
  localparam int CFG_INDEX_W    = 2;
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(64);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLS = CFG_INDEX_W'(0),
    REG_ROWS = CFG_INDEX_W'(1)
  } cfg_reg_t;

endpackage

// File: rtl/sats_cell.sv
// One cell of the line store: holds one previous-row sum.
// Loads its neighbor's value on a shift, or the new result when selected.
// Depends on sats_pkg.
`timescale 1ns / 1ps

module sats_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic                      load_new,
  input  logic [sats_pkg::SUM_W-1:0] neighbor,
  input  logic [sats_pkg::SUM_W-1:0] fresh,
  output logic [sats_pkg::SUM_W-1:0] held
);
  import sats_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= load_new ? fresh : neighbor;
    end
  end

endmodule

// File: rtl/sats_line.sv
// Line store built as a chain of sats_cell, shifting toward cell 0.
// The new result enters at the cell of the last active column.
// Depends on sats_pkg and sats_cell.
`timescale 1ns / 1ps

module sats_line #(
  parameter int MAX_WIDTH = sats_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         shift,
  input  logic [$clog2(MAX_WIDTH)-1:0] last_col,
  input  logic [sats_pkg::SUM_W-1:0]   fresh,
  output logic [sats_pkg::SUM_W-1:0]   head
);
  import sats_pkg::*;

  localparam int CIW = $clog2(MAX_WIDTH);

  logic [SUM_W-1:0] taps [MAX_WIDTH];

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    logic [SUM_W-1:0] nb;
    if (k == MAX_WIDTH - 1) begin : g_end
      assign nb = fresh;
    end else begin : g_mid
      assign nb = taps[k+1];
    end
    sats_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .load_new (last_col == CIW'(k)),
      .neighbor (nb),
      .fresh    (fresh),
      .held     (taps[k])
    );
  end

  assign head = taps[0];

endmodule

// File: rtl/summed_area_table_stream_core.sv
// Top level of the summed-area table stream core.
// Holds frame-size registers, positions, row running sum and output register.
// Depends on sats_pkg and sats_line.
`timescale 1ns / 1ps

// Takes one unsigned sample per beat in raster order and returns, in the
// next cycle, its integral-image entry plus a last_of_frame flag. One sample
// is accepted every cycle while in_stall is low; the entry is the row sum
// plus the line-store head (row 0 takes the row sum alone). The previous row
// lives in a chain of MAX_WIDTH cells, shifted once per accepted beat, so the
// value above the current sample is always at cell 0. Writing either size
// register restarts the frame; register values of 0 act as 1 and values above
// the maximum act as the maximum. No clearing pass is run after reset.
module summed_area_table_stream_core #(
  parameter int MAX_WIDTH  = sats_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sats_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sats_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sats_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sats_pkg::SAMPLE_W-1:0]    sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sats_pkg::SUM_W-1:0]       area_sum,
  output logic                             last_of_frame
);
  import sats_pkg::*;

  localparam int CIW = $clog2(MAX_WIDTH);
  localparam int RIW = $clog2(MAX_HEIGHT);
  localparam int CEW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int REW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

  logic [CFG_W-1:0] cols_in_use;
  logic [CFG_W-1:0] rows_in_use;
  logic [CIW-1:0]   col_pos;
  logic [RIW-1:0]   row_pos;
  logic [SUM_W-1:0] row_sum;

  logic [CEW-1:0]   cols_ext, cols_eff, cols_m1;
  logic [REW-1:0]   rows_ext, rows_eff, rows_m1;
  logic [CIW-1:0]   last_col;
  logic [RIW-1:0]   last_row;
  logic             fire;
  logic             at_last_col, at_last_row;
  logic [SUM_W-1:0] row_sum_next;
  logic [SUM_W-1:0] line_head;
  logic [SUM_W-1:0] result;

  always_comb begin
    cols_ext = CEW'(cols_in_use);
    priority if (cols_ext == '0) begin
      cols_eff = CEW'(1);
    end else if (cols_ext > CEW'(MAX_WIDTH)) begin
      cols_eff = CEW'(MAX_WIDTH);
    end else begin
      cols_eff = cols_ext;
    end
    cols_m1 = cols_eff - CEW'(1);

    rows_ext = REW'(rows_in_use);
    priority if (rows_ext == '0) begin
      rows_eff = REW'(1);
    end else if (rows_ext > REW'(MAX_HEIGHT)) begin
      rows_eff = REW'(MAX_HEIGHT);
    end else begin
      rows_eff = rows_ext;
    end
    rows_m1 = rows_eff - REW'(1);
  end

  assign last_col    = cols_m1[CIW-1:0];
  assign last_row    = rows_m1[RIW-1:0];
  assign at_last_col = (col_pos == last_col);
  assign at_last_row = (row_pos == last_row);

  assign in_stall = out_valid && out_stall;
  assign fire     = in_valid && !in_stall;

  assign row_sum_next = ((col_pos == '0) ? '0 : row_sum) + SUM_W'(sample);
  assign result       = (row_pos == '0) ? row_sum_next : line_head + row_sum_next;

  sats_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk      (clk),
    .shift    (fire),
    .last_col (last_col),
    .fresh    (result),
    .head     (line_head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= CFG_SIZE_RESET;
      rows_in_use <= CFG_SIZE_RESET;
      col_pos     <= '0;
      row_pos     <= '0;
      row_sum     <= '0;
    end else if (cfg_write && (cfg_index == REG_COLS || cfg_index == REG_ROWS)) begin
      unique case (cfg_index)
        REG_COLS: cols_in_use <= cfg_data;
        REG_ROWS: rows_in_use <= cfg_data;
        default:  ;
      endcase
      col_pos <= '0;
      row_pos <= '0;
      row_sum <= '0;
    end else if (fire) begin
      row_sum <= row_sum_next;
      if (at_last_col) begin
        col_pos <= '0;
        row_pos <= at_last_row ? '0 : row_pos + RIW'(1);
      end else begin
        col_pos <= col_pos + CIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      area_sum      <= result;
      last_of_frame <= at_last_col && at_last_row;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col_pos <= last_col)
    else $error("column position beyond active width");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    fire && at_last_col && at_last_row && !cfg_write |=> col_pos == '0 && row_pos == '0)
    else $error("positions did not wrap at end of frame");

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted beat produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

endmodule
